// ===== sv/bfr_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, command type and helpers for the bitstream field reader
// no dependencies

package bfr_pkg;

   // storage size and derived widths
   localparam int BUFFER_BYTES = 4096;
   localparam int ADDR_W       = $clog2(BUFFER_BYTES);
   localparam int LOADED_W     = $clog2(BUFFER_BYTES + 1);
   localparam int POS_W        = LOADED_W + 3;

   // fixed field widths
   localparam int BYTE_POS_W = 13;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 6;

   // a 32-bit field at any bit offset touches at most five bytes
   localparam int WINDOW_BYTES = 5;
   localparam int SLOT_W       = $clog2(WINDOW_BYTES);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   localparam logic [1:0] OP_CLEAR    = 2'd0;
   localparam logic [1:0] OP_APPEND   = 2'd1;
   localparam logic [1:0] OP_READ_RAW = 2'd2;
   localparam logic [1:0] OP_READ_INT = 2'd3;

   // integer coding modes
   localparam logic [1:0] MODE_PLAIN    = 2'd0;
   localparam logic [1:0] MODE_RANGE    = 2'd1;
   localparam logic [1:0] MODE_SOFT_MAX = 2'd2;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(VALUE_W);
   localparam logic [COUNT_W-1:0] FLAG_COUNT = COUNT_W'(1);

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_APPEND,
      CMD_READ
   } cmd_kind_type;

   // classified command; a read is one sub-read, or a flag sub-read then a second one
   typedef struct packed {
      cmd_kind_type         kind;
      logic [7:0]           data;
      logic [COUNT_W-1:0]   first_n;
      logic                 flag_first;
      logic [COUNT_W-1:0]   soft_n;
      logic [VALUE_W-1:0]   lo;
   } cmd_type;

   // bit position rounded up to whole bytes
   function automatic logic [BYTE_POS_W-1:0] byte_pos_of(input logic [POS_W-1:0] pos);
      logic [POS_W:0]            rounded;
      logic [POS_W+BYTE_POS_W:0] wide;
      rounded = {1'b0, pos} + (POS_W + 1)'(7);
      wide    = (POS_W + BYTE_POS_W + 1)'(rounded >> 3);
      return wide[BYTE_POS_W-1:0];
   endfunction

endpackage

// ===== sv/bfr_req_if.sv =====
`timescale 1ns / 1ps
// request channel of the bitstream field reader: valid, ready and request payload
// no dependencies

interface bfr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [7:0]         byte_in;
   logic [5:0]         raw_width;
   logic [1:0]         int_mode;
   logic signed [31:0] min_value;
   logic signed [31:0] max_value;

   modport source (
      output valid, operation, byte_in, raw_width, int_mode, min_value, max_value,
      input  ready
   );

   modport sink (
      input  valid, operation, byte_in, raw_width, int_mode, min_value, max_value,
      output ready
   );
endinterface

// ===== sv/bfr_rsp_if.sv =====
`timescale 1ns / 1ps
// response channel of the bitstream field reader: valid, ready and result payload
// no dependencies

interface bfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        out_of_data;
   logic [12:0] byte_position;

   modport source (
      output valid, value, out_of_data, byte_position,
      input  ready
   );

   modport sink (
      input  valid, value, out_of_data, byte_position,
      output ready
   );
endinterface

// ===== sv/bitstream_field_reader.sv =====
`timescale 1ns / 1ps
// top level of the bitstream field reader: front end, command queue, back end
// depends on bfr_pkg, bfr_req_if, bfr_rsp_if, bfr_front, bfr_cmd_fifo, bfr_back

// A byte buffer with a bit read position, read least significant bit first. Each request
// transaction clears the buffer, appends one byte, reads a raw field of 0 to 32 bits, or
// reads an integer in plain, range or soft-max coding; only reads produce a response
// transaction, and responses come out in request order. The front end classifies each
// request into a registered command (it works out the range field width) and hands it to a
// four-entry command queue, so requests keep being taken, until the queue fills, while the
// back end is busy or a response waits in its output register. The back end takes one
// command at a time: clear and append are done in idle; a read runs, for each sub-read,
// through start, fetch of every stored byte the field touches (one to five) over the byte
// store's single read port, collect and extract, then finish; a sub-read of zero width or
// one that runs short goes from start straight to finish. Soft max adds a flag sub-read. A
// read that runs past the loaded bytes returns value zero with out_of_data set and
// leaves the position where that sub-read began. The store needs no clearing pass after
// reset or clear: only bytes below the fill count are ever read.

module bitstream_field_reader (
   input  logic      clock,
   input  logic      reset,
   bfr_req_if.sink   req_if,
   bfr_rsp_if.source rsp_if
);

   // front end to queue
   logic             push_valid;
   logic             push_ready;
   bfr_pkg::cmd_type push_cmd;

   // queue to back end
   logic             pop_valid;
   logic             pop_ready;
   bfr_pkg::cmd_type pop_cmd;

   // classify request transactions into commands
   bfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // decouples request acceptance from execution
   bfr_cmd_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // byte store, position tracking and response register
   bfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== sv/bfr_ram.sv =====
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module bfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bfr_front.sv =====
`timescale 1ns / 1ps
// front end: accepts request transactions and turns them into queue commands
// depends on bfr_pkg and bfr_req_if

module bfr_front (
   input  logic             clock,
   input  logic             reset,
   bfr_req_if.sink          req_if,
   output logic             push_valid,
   input  logic             push_ready,
   output bfr_pkg::cmd_type push_cmd
);

   logic             front_valid_ff, front_valid_in;
   bfr_pkg::cmd_type front_cmd_ff, front_cmd_in;
   bfr_pkg::cmd_type cmd;
   logic             accept;
   logic [32:0]      span;
   logic [bfr_pkg::COUNT_W-1:0] range_n;
   logic [bfr_pkg::COUNT_W-1:0] soft_n;

   // number of significant bits
   function automatic logic [bfr_pkg::COUNT_W-1:0] bit_len(
      input logic [bfr_pkg::VALUE_W-1:0] d
   );
      logic [bfr_pkg::COUNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < bfr_pkg::VALUE_W; i++) begin
         if (d[i]) begin
            n = bfr_pkg::COUNT_W'(i + 1);
         end
      end
      return n;
   endfunction

   // exact 33-bit difference; positive only when max is above min
   assign span    = {req_if.max_value[31], req_if.max_value}
                  - {req_if.min_value[31], req_if.min_value};
   assign range_n = (req_if.max_value > req_if.min_value) ? bit_len(span[31:0]) : '0;
   assign soft_n  = (req_if.max_value > 32'sd0)
                  ? bit_len({1'b0, req_if.max_value[30:0]}) : '0;

   always_comb begin
      cmd         = '0;
      cmd.kind    = bfr_pkg::CMD_READ;
      cmd.data    = req_if.byte_in;
      case (req_if.operation)
         bfr_pkg::OP_CLEAR: begin
            cmd.kind = bfr_pkg::CMD_CLEAR;
         end
         bfr_pkg::OP_APPEND: begin
            cmd.kind = bfr_pkg::CMD_APPEND;
         end
         bfr_pkg::OP_READ_RAW: begin
            cmd.first_n = (req_if.raw_width > bfr_pkg::FULL_COUNT)
                        ? bfr_pkg::FULL_COUNT : req_if.raw_width;
         end
         bfr_pkg::OP_READ_INT: begin
            case (req_if.int_mode)
               bfr_pkg::MODE_PLAIN: begin
                  cmd.first_n = bfr_pkg::FULL_COUNT;
               end
               bfr_pkg::MODE_RANGE: begin
                  cmd.first_n = range_n;
                  cmd.lo      = req_if.min_value;
               end
               bfr_pkg::MODE_SOFT_MAX: begin
                  cmd.first_n    = bfr_pkg::FLAG_COUNT;
                  cmd.flag_first = 1'b1;
                  cmd.soft_n     = soft_n;
               end
               default: begin
                  // unused mode: no read, value zero
                  cmd.first_n = '0;
               end
            endcase
         end
         default: begin
            cmd.kind = bfr_pkg::CMD_CLEAR;
         end
      endcase
   end

   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      front_valid_in = front_valid_ff;
      front_cmd_in   = front_cmd_ff;
      if (push_ready) begin
         front_valid_in = 1'b0;
      end
      if (accept) begin
         front_valid_in = 1'b1;
         front_cmd_in   = cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_cmd_ff <= front_cmd_in;
   end

   assign req_if.ready = !front_valid_ff || push_ready;
   assign push_valid   = front_valid_ff;
   assign push_cmd     = front_cmd_ff;

endmodule

// ===== sv/bfr_cmd_fifo.sv =====
`timescale 1ns / 1ps
// short command queue between front end and back end
// depends on bfr_pkg

module bfr_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  bfr_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output bfr_pkg::cmd_type pop_cmd
);

   bfr_pkg::cmd_type                 entry_ff [bfr_pkg::QUEUE_DEPTH];
   logic [bfr_pkg::QUEUE_IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [bfr_pkg::QUEUE_IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [bfr_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                             do_push, do_pop;

   function automatic logic [bfr_pkg::QUEUE_IDX_W-1:0] next_ptr(
      input logic [bfr_pkg::QUEUE_IDX_W-1:0] p
   );
      return (p == bfr_pkg::QUEUE_IDX_W'(bfr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (count_ff != bfr_pkg::QUEUE_CNT_W'(bfr_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/bfr_back.sv =====
`timescale 1ns / 1ps
// back end: byte store, bit position and the sub-read sequencer
// depends on bfr_pkg, bfr_rsp_if and bfr_ram

module bfr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  bfr_pkg::cmd_type pop_cmd,
   bfr_rsp_if.source        rsp_if
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_START   = 6'b000010,
      ST_FETCH   = 6'b000100,
      ST_COLLECT = 6'b001000,
      ST_EXTRACT = 6'b010000,
      ST_FINISH  = 6'b100000
   } state_type;

   localparam int WIN_W = bfr_pkg::WINDOW_BYTES * 8;

   state_type                        state_ff, state_in;
   logic [bfr_pkg::LOADED_W-1:0]     loaded_ff, loaded_in;
   logic [bfr_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [bfr_pkg::VALUE_W-1:0]      lo_ff, lo_in;
   logic                             soft_ff, soft_in;
   logic [bfr_pkg::COUNT_W-1:0]      soft_n_ff, soft_n_in;
   logic [bfr_pkg::COUNT_W-1:0]      sub_n_ff, sub_n_in;
   logic [bfr_pkg::VALUE_W-1:0]      bits_ff, bits_in;
   logic                             fail_ff, fail_in;
   logic [bfr_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [bfr_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   logic [bfr_pkg::SLOT_W-1:0]       last_slot_ff, last_slot_in;
   logic                             pend_ff, pend_in;
   logic [bfr_pkg::SLOT_W-1:0]       pend_slot_ff, pend_slot_in;
   logic [WIN_W-1:0]                 window_ff, window_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [bfr_pkg::VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                             rsp_oob_ff, rsp_oob_in;
   logic [bfr_pkg::BYTE_POS_W-1:0]   rsp_bpos_ff, rsp_bpos_in;

   logic                             ram_wr_en, ram_rd_en;
   logic [bfr_pkg::ADDR_W-1:0]       ram_rd_addr;
   logic [7:0]                       ram_rd_data;

   logic [bfr_pkg::POS_W:0]          pos_end, data_end;
   logic                             over;
   logic [bfr_pkg::COUNT_W-1:0]      span_end;
   logic [WIN_W-1:0]                 shifted;
   logic [bfr_pkg::VALUE_W-1:0]      mask, field;

   bfr_ram #(
      .WIDTH (8),
      .DEPTH (bfr_pkg::BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (loaded_ff[bfr_pkg::ADDR_W-1:0]),
      .wr_data (pop_cmd.data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shortage check and byte span of the pending sub-read
   assign pos_end  = {1'b0, pos_ff} + (bfr_pkg::POS_W + 1)'(sub_n_ff);
   assign data_end = (bfr_pkg::POS_W + 1)'({loaded_ff, 3'b000});
   assign over     = (pos_end > data_end);
   assign span_end = bfr_pkg::COUNT_W'(pos_ff[2:0]) + sub_n_ff - 1'b1;

   // align the fetched bytes and keep the requested bits
   assign shifted = window_ff >> pos_ff[2:0];
   assign mask    = (sub_n_ff >= bfr_pkg::FULL_COUNT)
                  ? '1 : ((bfr_pkg::VALUE_W'(1) << sub_n_ff) - 1'b1);
   assign field   = shifted[bfr_pkg::VALUE_W-1:0] & mask;

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      pos_in       = pos_ff;
      lo_in        = lo_ff;
      soft_in      = soft_ff;
      soft_n_in    = soft_n_ff;
      sub_n_in     = sub_n_ff;
      bits_in      = bits_ff;
      fail_in      = fail_ff;
      addr_in      = addr_ff;
      slot_in      = slot_ff;
      last_slot_in = last_slot_ff;
      pend_in      = 1'b0;
      pend_slot_in = slot_ff;
      window_in    = window_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_oob_in   = rsp_oob_ff;
      rsp_bpos_in  = rsp_bpos_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = addr_ff;
      pop_ready    = 1'b0;

      if (pend_ff) begin
         window_in[pend_slot_ff*8 +: 8] = ram_rd_data;
      end
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               case (pop_cmd.kind)
                  bfr_pkg::CMD_CLEAR: begin
                     loaded_in = '0;
                     pos_in    = '0;
                  end
                  bfr_pkg::CMD_APPEND: begin
                     if (loaded_ff < bfr_pkg::LOADED_W'(bfr_pkg::BUFFER_BYTES)) begin
                        ram_wr_en = 1'b1;
                        loaded_in = loaded_ff + 1'b1;
                     end
                  end
                  bfr_pkg::CMD_READ: begin
                     lo_in     = pop_cmd.lo;
                     soft_in   = pop_cmd.flag_first;
                     soft_n_in = pop_cmd.soft_n;
                     sub_n_in  = pop_cmd.first_n;
                     bits_in   = '0;
                     fail_in   = 1'b0;
                     state_in  = ST_START;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_START: begin
            if (sub_n_ff == '0) begin
               bits_in  = '0;
               state_in = ST_FINISH;
            end else if (over) begin
               fail_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               addr_in      = pos_ff[bfr_pkg::ADDR_W+2:3];
               slot_in      = '0;
               last_slot_in = bfr_pkg::SLOT_W'(span_end >> 3);
               state_in     = ST_FETCH;
            end
         end
         ST_FETCH: begin
            ram_rd_en    = 1'b1;
            pend_in      = 1'b1;
            pend_slot_in = slot_ff;
            addr_in      = addr_ff + 1'b1;
            slot_in      = slot_ff + 1'b1;
            if (slot_ff == last_slot_ff) begin
               state_in = ST_COLLECT;
            end
         end
         ST_COLLECT: begin
            state_in = ST_EXTRACT;
         end
         ST_EXTRACT: begin
            pos_in = pos_ff + bfr_pkg::POS_W'(sub_n_ff);
            if (soft_ff) begin
               // flag bit picks range over 0..max or a plain read
               soft_in = 1'b0;
               if (field[0]) begin
                  sub_n_in = soft_n_ff;
               end else begin
                  sub_n_in = bfr_pkg::FULL_COUNT;
               end
               state_in = ST_START;
            end else begin
               bits_in  = field;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = fail_ff ? '0 : lo_ff + bits_ff;
               rsp_oob_in   = fail_ff;
               rsp_bpos_in  = bfr_pkg::byte_pos_of(pos_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loaded_ff    <= '0;
         pos_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         pos_ff       <= pos_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      soft_ff      <= soft_in;
      soft_n_ff    <= soft_n_in;
      sub_n_ff     <= sub_n_in;
      bits_ff      <= bits_in;
      fail_ff      <= fail_in;
      addr_ff      <= addr_in;
      slot_ff      <= slot_in;
      last_slot_ff <= last_slot_in;
      pend_slot_ff <= pend_slot_in;
      window_ff    <= window_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oob_ff   <= rsp_oob_in;
      rsp_bpos_ff  <= rsp_bpos_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.value         = rsp_value_ff;
   assign rsp_if.out_of_data   = rsp_oob_ff;
   assign rsp_if.byte_position = rsp_bpos_ff;

endmodule

// ===== sv/bfr_checker.sv =====
`timescale 1ns / 1ps
// port-level checks on the response channel of the bitstream field reader
// depends on bfr_pkg; bound to bitstream_field_reader

module bfr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [bfr_pkg::VALUE_W-1:0]     rsp_value,
   input logic                            rsp_out_of_data,
   input logic [bfr_pkg::BYTE_POS_W-1:0]  rsp_byte_position
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response stays up
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_out_of_data)
                                  && $stable(rsp_byte_position))
      else $error("response payload changed while stalled");

   // a failed read reports value zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_data |-> rsp_value == '0)
      else $error("out of data with nonzero value");

   // position never beyond the buffer
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_position
                    <= bfr_pkg::BYTE_POS_W'(bfr_pkg::BUFFER_BYTES))
      else $error("byte position beyond buffer");

endmodule

bind bitstream_field_reader bfr_checker u_bfr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_value         (rsp_if.value),
   .rsp_out_of_data   (rsp_if.out_of_data),
   .rsp_byte_position (rsp_if.byte_position)
);
